[hw/rtl/mds_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers for the medium distance sampler
package mds_pkg;

  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [35:0] EXP_CUT  = 36'hC_0000_0000;
  localparam logic [31:0] EPS_LSB  = 32'd7;

  localparam logic [1:0] OUT_PASSED    = 2'd0;
  localparam logic [1:0] OUT_SCATTERED = 2'd1;
  localparam logic [1:0] OUT_ABSORBED  = 2'd2;

  typedef struct packed {
    logic [31:0] len;
    logic [15:0] xi;
    logic [15:0] xa;
  } item_t;

  // m * ln2 in Q.32, m up to 17
  function automatic logic [35:0] ln2_mult(input logic [4:0] m);
    logic [35:0] prod;
    prod = 36'(m) * 36'(LN2_Q32);
    return prod;
  endfunction

endpackage

[hw/rtl/mds_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module mds_div #(
  parameter int RW = 24,
  parameter int DW = 37,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [RW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [DW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [RW-1:0] rem_q [1:DW];
  logic [DW-1:0] dvd_q [1:DW];
  logic [DW-1:0] quo_q [1:DW];
  logic [RW-1:0] dvs_q [1:DW];
  logic [TW-1:0] tag_q [1:DW];
  logic          v_q   [1:DW];

  for (genvar j = 1; j <= DW; j++) begin : g_step
    logic [RW-1:0] rem_s;
    logic [RW-1:0] dvs_s;
    logic [DW-1:0] dvd_s;
    logic [DW-1:0] quo_s;
    logic [TW-1:0] tag_s;
    logic          v_s;
    logic [RW:0]   w;
    logic          ge;

    if (j == 1) begin : g_first
      assign rem_s = rem_i;
      assign dvs_s = dvs_i;
      assign dvd_s = dvd_i;
      assign quo_s = '0;
      assign tag_s = tag_i;
      assign v_s   = valid_i;
    end else begin : g_next
      assign rem_s = rem_q[j-1];
      assign dvs_s = dvs_q[j-1];
      assign dvd_s = dvd_q[j-1];
      assign quo_s = quo_q[j-1];
      assign tag_s = tag_q[j-1];
      assign v_s   = v_q[j-1];
    end

    assign w  = {rem_s, dvd_s[DW-1]};
    assign ge = w >= {1'b0, dvs_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? RW'(w - {1'b0, dvs_s}) : w[RW-1:0];
        dvd_q[j] <= dvd_s << 1;
        quo_q[j] <= {quo_s[DW-2:0], ge};
        dvs_q[j] <= dvs_s;
        tag_q[j] <= tag_s;
      end
    end
  end

  assign valid_o = v_q[DW];
  assign quo_o   = quo_q[DW];
  assign tag_o   = tag_q[DW];

endmodule

[hw/rtl/mds_neg_exp.sv]
`timescale 1ns / 1ps
// pipelined exp(-x): range reduction by ln2, horner taylor series, rounding to q1.16
module mds_neg_exp
  import mds_pkg::*;
#(
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [55:0]   x_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [16:0]   tau_o,
  output logic [TW-1:0] tag_o
);

  localparam int NT = 13;
  localparam int SW = TW + 38;  // tag, zero flag, k, r

  logic [SW-1:0] sdb_q [0:NT];
  logic [32:0]   pb_q  [0:NT];
  logic          vb_q  [0:NT];
  logic [SW-1:0] sda_q [1:NT];
  logic [31:0]   qa_q  [1:NT];
  logic          va_q  [1:NT];

  logic          in_range;
  logic [4:0]    k;
  logic [35:0]   rw;

  // range reduction: k = floor(x / ln2) from a row of compares
  always_comb begin
    in_range = (x_i[55:36] == 20'd0) && (x_i[35:0] < EXP_CUT);
    k = 5'd0;
    for (int m = 1; m <= 17; m++) begin
      if (x_i[35:0] >= ln2_mult(5'(m))) begin
        k = 5'(m);
      end
    end
    rw = x_i[35:0] - ln2_mult(k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q[0] <= 1'b0;
    end else if (en_i) begin
      vb_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdb_q[0] <= {tag_i, ~in_range, k, rw[31:0]};
      pb_q[0]  <= ONE_Q32;
    end
  end

  for (genvar j = 1; j <= NT; j++) begin : g_term
    localparam int N = NT + 1 - j;
    // floor(q / N) as a reciprocal multiply, exact for q below 2^32
    localparam logic [36:0] RECIP = 37'(((64'd1 << 36) + 64'(N) - 64'd1) / 64'(N));
    logic [64:0] prod_w;
    logic [68:0] quo_w;

    assign prod_w = 65'(sdb_q[j-1][31:0]) * 65'(pb_q[j-1]);
    assign quo_w  = 69'(qa_q[j]) * 69'(RECIP);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[j] <= 1'b0;
        vb_q[j] <= 1'b0;
      end else if (en_i) begin
        va_q[j] <= vb_q[j-1];
        vb_q[j] <= va_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qa_q[j]  <= prod_w[63:32];
        sda_q[j] <= sdb_q[j-1];
        pb_q[j]  <= ONE_Q32 - quo_w[68:36];
        sdb_q[j] <= sda_q[j];
      end
    end
  end

  logic [5:0]    sh;
  logic [33:0]   rnd;
  logic [33:0]   res;
  logic          v_q;
  logic [16:0]   tau_q;
  logic [TW-1:0] tag_q;

  always_comb begin
    sh  = 6'(sdb_q[NT][36:32]) + 6'd16;
    rnd = 34'(pb_q[NT]) + (34'd1 << (sh - 6'd1));
    res = rnd >> sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= vb_q[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tau_q <= sdb_q[NT][37] ? 17'd0 : res[16:0];
      tag_q <= sdb_q[NT][SW-1:38];
    end
  end

  assign valid_o = v_q;
  assign tau_o   = tau_q;
  assign tag_o   = tag_q;

endmodule

[hw/rtl/medium_distance_sampler.sv]
`timescale 1ns / 1ps
// Free-flight distance sampler for a homogeneous medium. One ray segment is taken per clock
// while the pipeline advances; the pipeline holds as a whole while a finished result is stalled
// at the output register. It is built from the chain -ln(1 - rand_distance) (32-stage
// divider and an 11-stage series), the distance division by sigma_mean (37 stages) and
// 28-stage exp units, one for the pass test and three in parallel for the channel
// transmittances. Registers are to be written over the APB port by the user only while no
// segment is in flight; the block itself does not enforce this.
module medium_distance_sampler
  import mds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] segment_length_i,
  input  logic [15:0] rand_distance_i,
  input  logic [15:0] rand_absorb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [31:0] distance_out_o,
  output logic [16:0] tau_red_o,
  output logic [16:0] tau_green_o,
  output logic [16:0] tau_blue_o,
  output logic [23:0] pdf_red_o,
  output logic [23:0] pdf_green_o,
  output logic [23:0] pdf_blue_o
);

  localparam logic [2:0] REG_SIGMA_RED   = 3'd0;
  localparam logic [2:0] REG_SIGMA_GREEN = 3'd1;
  localparam logic [2:0] REG_SIGMA_BLUE  = 3'd2;
  localparam logic [2:0] REG_SIGMA_MEAN  = 3'd3;
  localparam logic [2:0] REG_ABSORB      = 3'd4;
  localparam int         NS = 11;

  // configuration registers
  logic [23:0] sig_r_q, sig_g_q, sig_b_q, sm_q;
  logic [15:0] ap_q;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_r_q <= 24'd0;
      sig_g_q <= 24'd0;
      sig_b_q <= 24'd0;
      sm_q    <= 24'd65536;
      ap_q    <= 16'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SIGMA_RED:   sig_r_q <= pwdata[23:0];
        REG_SIGMA_GREEN: sig_g_q <= pwdata[23:0];
        REG_SIGMA_BLUE:  sig_b_q <= pwdata[23:0];
        REG_SIGMA_MEAN:  sm_q    <= pwdata[23:0];
        REG_ABSORB:      ap_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIGMA_RED:   prdata = {8'd0, sig_r_q};
      REG_SIGMA_GREEN: prdata = {8'd0, sig_g_q};
      REG_SIGMA_BLUE:  prdata = {8'd0, sig_b_q};
      REG_SIGMA_MEAN:  prdata = {8'd0, sm_q};
      REG_ABSORB:      prdata = {16'd0, ap_q};
      default:         prdata = 32'd0;
    endcase
  end

  // whole pipeline moves unless the output register holds a stalled result
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // input stage
  logic  v1_q;
  item_t it1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q <= '{len: segment_length_i, xi: rand_distance_i, xa: rand_absorb_i};
    end
  end

  // normalise u = 1 - xi to mf in [1, 2)
  logic [16:0] u;
  logic [4:0]  e_w;
  logic [32:0] mf;
  logic        v2_q;
  logic [33:0] rem2_q, dvs2_q;
  logic [68:0] tag2_q;

  always_comb begin
    u   = 17'd65536 - 17'(it1_q.xi);
    e_w = 5'd0;
    for (int b = 1; b <= 16; b++) begin
      if (u[b]) begin
        e_w = 5'(b);
      end
    end
    mf = 33'(u) << (6'd32 - 6'(e_w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem2_q <= 34'(mf) - 34'(ONE_Q32);
      dvs2_q <= 34'(mf) + 34'(ONE_Q32);
      tag2_q <= {it1_q, e_w};
    end
  end

  // t = (mf - 1) / (mf + 1)
  logic        vt;
  logic [31:0] t_w;
  logic [68:0] tagt;

  mds_div #(.RW(34), .DW(32), .TW(69)) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .rem_i   (rem2_q),
    .dvd_i   (32'd0),
    .dvs_i   (dvs2_q),
    .tag_i   (tag2_q),
    .valid_o (vt),
    .quo_o   (t_w),
    .tag_o   (tagt)
  );

  logic        v3_q;
  logic [31:0] t3_q, t23_q;
  logic [68:0] tag3_q;
  logic [63:0] tsq;

  assign tsq = 64'(t_w) * 64'(t_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= vt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_q   <= t_w;
      t23_q  <= tsq[63:32];
      tag3_q <= tagt;
    end
  end

  // atanh series in t^2, one term per stage
  logic [33:0] s_q   [0:NS-1];
  logic [31:0] ts_q  [0:NS-1];
  logic [31:0] t2s_q [0:NS-1];
  logic [68:0] tags_q [0:NS-1];
  logic        vs_q  [0:NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_series
    localparam int K = NS - 1 - i;
    localparam logic [33:0] CK = 34'((64'd1 << 32) / 64'(2 * K + 1));
    logic [33:0] s_in;
    logic [31:0] t_in, t2_in;
    logic [68:0] tag_in;
    logic        v_in;
    logic [65:0] m_w;

    if (i == 0) begin : g_first
      assign s_in   = 34'd0;
      assign t_in   = t3_q;
      assign t2_in  = t23_q;
      assign tag_in = tag3_q;
      assign v_in   = v3_q;
    end else begin : g_next
      assign s_in   = s_q[i-1];
      assign t_in   = ts_q[i-1];
      assign t2_in  = t2s_q[i-1];
      assign tag_in = tags_q[i-1];
      assign v_in   = vs_q[i-1];
    end

    assign m_w = 66'(t2_in) * 66'(s_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[i] <= 1'b0;
      end else if (adv) begin
        vs_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[i]    <= CK + m_w[65:32];
        ts_q[i]   <= t_in;
        t2s_q[i]  <= t2_in;
        tags_q[i] <= tag_in;
      end
    end
  end

  logic        vl_q;
  logic [34:0] lnm_q;
  logic [68:0] tagl_q;
  logic [65:0] ls_w;

  assign ls_w = 66'(ts_q[NS-1]) * 66'(s_q[NS-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= 1'b0;
    end else if (adv) begin
      vl_q <= vs_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lnm_q  <= {ls_w[65:32], 1'b0};
      tagl_q <= tags_q[NS-1];
    end
  end

  // -ln(u) = (16 - e) ln2 - ln(mf), clamped at zero
  logic        vn_q;
  logic [35:0] n_q;
  item_t       itn_q;
  logic [35:0] total;

  assign total = ln2_mult(5'd16 - tagl_q[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (adv) begin
      vn_q <= vl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q   <= (total > 36'(lnm_q)) ? total - 36'(lnm_q) : 36'd0;
      itn_q <= tagl_q[68:5];
    end
  end

  logic        vd_q;
  logic [36:0] dvd_q;
  item_t       itd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvd_q <= 37'(n_q) + 37'(sm_q >> 1);
      itd_q <= itn_q;
    end
  end

  // distance = round(n / sigma_mean)
  logic        vq;
  logic [36:0] quo_ds;
  logic [63:0] tagq;

  mds_div #(.RW(24), .DW(37), .TW(64)) u_div_ds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vd_q),
    .rem_i   (24'd0),
    .dvd_i   (dvd_q),
    .dvs_i   (sm_q),
    .tag_i   (itd_q),
    .valid_o (vq),
    .quo_o   (quo_ds),
    .tag_o   (tagq)
  );

  logic        vx_q;
  logic [55:0] xm_q;
  logic [95:0] tagx_q;
  item_t       itq;

  assign itq = tagq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= 1'b0;
    end else if (adv) begin
      vx_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xm_q   <= 56'(sm_q) * 56'(itq.len);
      tagx_q <= {tagq, (quo_ds[36:32] != 5'd0) ? 32'hFFFF_FFFF : quo_ds[31:0]};
    end
  end

  // transmittance over the whole segment at the mean extinction
  logic        vm;
  logic [16:0] em;
  logic [95:0] tagm;

  mds_neg_exp #(.TW(96)) u_exp_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vx_q),
    .x_i     (xm_q),
    .tag_i   (tagx_q),
    .valid_o (vm),
    .tau_o   (em),
    .tag_o   (tagm)
  );

  item_t       itm;
  logic [31:0] dsm;
  logic        passed, absorbed;

  assign itm = tagm[95:32];
  assign dsm = tagm[31:0];

  always_comb begin
    passed = ({1'b0, itm.xi} >= (17'd65536 - em)) || (sm_q == 24'd0) ||
             ((33'(dsm) + 33'(EPS_LSB)) > 33'(itm.len));
    absorbed = !passed && ((itm.xa < ap_q) || (dsm < EPS_LSB));
  end

  logic        ve_q;
  logic [31:0] d_q, dse_q;
  logic        pass_e_q, abs_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv) begin
      ve_q <= vm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q      <= passed ? itm.len : dsm;
      dse_q    <= dsm;
      pass_e_q <= passed;
      abs_e_q  <= absorbed;
    end
  end

  // optical depth per channel
  logic        vy_q;
  logic [55:0] xr_q, xg_q, xb_q;
  logic [31:0] dsy_q;
  logic        pass_y_q, abs_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vy_q <= 1'b0;
    end else if (adv) begin
      vy_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xr_q     <= 56'(sig_r_q) * 56'(d_q);
      xg_q     <= 56'(sig_g_q) * 56'(d_q);
      xb_q     <= 56'(sig_b_q) * 56'(d_q);
      dsy_q    <= dse_q;
      pass_y_q <= pass_e_q;
      abs_y_q  <= abs_e_q;
    end
  end

  // the item's side data is spread over the three channel units
  logic        vr, vg, vb;
  logic [16:0] tr, tg, tb;
  logic [31:0] dsz;
  logic        pass_z, abs_z;

  mds_neg_exp #(.TW(32)) u_exp_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vy_q),
    .x_i     (xr_q),
    .tag_i   (dsy_q),
    .valid_o (vr),
    .tau_o   (tr),
    .tag_o   (dsz)
  );

  mds_neg_exp #(.TW(1)) u_exp_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vy_q),
    .x_i     (xg_q),
    .tag_i   (pass_y_q),
    .valid_o (vg),
    .tau_o   (tg),
    .tag_o   (pass_z)
  );

  mds_neg_exp #(.TW(1)) u_exp_blue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vy_q),
    .x_i     (xb_q),
    .tag_i   (abs_y_q),
    .valid_o (vb),
    .tau_o   (tb),
    .tag_o   (abs_z)
  );

  // density = tau * sigma, rounded
  logic        vp_q;
  logic [24:0] pr_q, pg_q, pbl_q;
  logic [16:0] tr_q, tg_q, tb_q;
  logic [31:0] dsp_q;
  logic        pass_p_q, abs_p_q;
  logic [40:0] mr, mg, mb;

  assign mr = 41'(tr) * 41'(sig_r_q) + 41'd32768;
  assign mg = 41'(tg) * 41'(sig_g_q) + 41'd32768;
  assign mb = 41'(tb) * 41'(sig_b_q) + 41'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= vr & vg & vb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q     <= mr[40:16];
      pg_q     <= mg[40:16];
      pbl_q    <= mb[40:16];
      tr_q     <= tr;
      tg_q     <= tg;
      tb_q     <= tb;
      dsp_q    <= dsz;
      pass_p_q <= pass_z;
      abs_p_q  <= abs_z;
    end
  end

  // result assembly
  logic [1:0]  oc_d;
  logic [31:0] dist_d;
  logic [16:0] tr_d, tg_d, tb_d;
  logic [23:0] pr_d, pg_d, pb_d;
  logic [23:0] sr, sg, sb;
  logic        tau_zero, pdf_zero;

  always_comb begin
    sr = pr_q[24] ? 24'hFF_FFFF : pr_q[23:0];
    sg = pg_q[24] ? 24'hFF_FFFF : pg_q[23:0];
    sb = pbl_q[24] ? 24'hFF_FFFF : pbl_q[23:0];
    tau_zero = (tr_q == 17'd0) && (tg_q == 17'd0) && (tb_q == 17'd0);
    pdf_zero = (sr == 24'd0) && (sg == 24'd0) && (sb == 24'd0);
    oc_d   = OUT_SCATTERED;
    dist_d = dsp_q;
    tr_d   = tr_q;
    tg_d   = tg_q;
    tb_d   = tb_q;
    pr_d   = pdf_zero ? 24'(EPS_LSB) : sr;
    pg_d   = pdf_zero ? 24'(EPS_LSB) : sg;
    pb_d   = pdf_zero ? 24'(EPS_LSB) : sb;
    if (pass_p_q) begin
      oc_d   = OUT_PASSED;
      dist_d = 32'd0;
      // fully opaque on pass still reports a tiny transmittance
      tr_d   = tau_zero ? 17'(EPS_LSB) : tr_q;
      tg_d   = tau_zero ? 17'(EPS_LSB) : tg_q;
      tb_d   = tau_zero ? 17'(EPS_LSB) : tb_q;
      pr_d   = 24'(tr_d);
      pg_d   = 24'(tg_d);
      pb_d   = 24'(tb_d);
    end else if (abs_p_q) begin
      oc_d   = OUT_ABSORBED;
      dist_d = 32'd0;
      tr_d   = 17'd0;
      tg_d   = 17'd0;
      tb_d   = 17'd0;
      pr_d   = 24'd0;
      pg_d   = 24'd0;
      pb_d   = 24'd0;
    end
  end

  logic [1:0]  oc_q;
  logic [31:0] dist_q;
  logic [16:0] otr_q, otg_q, otb_q;
  logic [23:0] opr_q, opg_q, opb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q   <= oc_d;
      dist_q <= dist_d;
      otr_q  <= tr_d;
      otg_q  <= tg_d;
      otb_q  <= tb_d;
      opr_q  <= pr_d;
      opg_q  <= pg_d;
      opb_q  <= pb_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = oc_q;
  assign distance_out_o = dist_q;
  assign tau_red_o      = otr_q;
  assign tau_green_o    = otg_q;
  assign tau_blue_o     = otb_q;
  assign pdf_red_o      = opr_q;
  assign pdf_green_o    = opg_q;
  assign pdf_blue_o     = opb_q;

endmodule
